// File: rtl/srl_pkg.sv
// Shared types and constants of the symbol range lookup block.
package srl_pkg;

  localparam int ADDR_W          = 32;
  localparam int LENGTH_W        = 32;
  localparam int KIND_W          = 4;
  localparam int NAME_W          = 32;
  localparam int INDEX_W         = 8;
  localparam int COUNT_W         = 9;
  localparam int DEFAULT_TABLE_DEPTH = 256;

  localparam logic [KIND_W-1:0] KIND_FUNCTION = 4'h2;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } command_t;

  // One symbol table slot as held in the entry memory.
  typedef struct packed {
    logic [ADDR_W-1:0]   start;
    logic [LENGTH_W-1:0] length;
    logic [KIND_W-1:0]   kind;
    logic [NAME_W-1:0]   name_offset;
  } entry_t;

endpackage

// File: rtl/srl_in_if.sv
// Request channel: table writes and address lookups.
interface srl_in_if;
  import srl_pkg::*;

  logic                valid;
  logic                ready;
  command_t            command;
  logic [INDEX_W-1:0]  entry_index;
  logic [ADDR_W-1:0]   entry_start;
  logic [LENGTH_W-1:0] entry_length;
  logic [KIND_W-1:0]   entry_kind;
  logic [NAME_W-1:0]   entry_name_offset;
  logic [ADDR_W-1:0]   lookup_address;

  modport source (
    output valid, command, entry_index, entry_start, entry_length, entry_kind,
           entry_name_offset, lookup_address,
    input  ready
  );

  modport sink (
    input  valid, command, entry_index, entry_start, entry_length, entry_kind,
           entry_name_offset, lookup_address,
    output ready
  );
endinterface

// File: rtl/srl_out_if.sv
// Response channel: one lookup result per lookup transaction.
interface srl_out_if;
  import srl_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [NAME_W-1:0] match_name_offset;
  logic [ADDR_W-1:0] match_offset;

  modport source (
    output valid, found, match_name_offset, match_offset,
    input  ready
  );

  modport sink (
    input  valid, found, match_name_offset, match_offset,
    output ready
  );
endinterface

// File: rtl/symbol_range_lookup_core.sv
// Symbol range lookup: a table of symbol entries (start, size, type, name
// offset) held in one synchronous memory, and an address resolver over it.
// A write transaction stores one entry and returns nothing; a write to a
// slot at or beyond TABLE_DEPTH is dropped. A lookup transaction scans slots
// 0 .. entry_count-1 (capped at TABLE_DEPTH) in order, one slot per cycle
// through the memory's single read port, and returns one result: the first
// function entry (type 2) with start <= address < start + size, the size sum
// taken at 33 bits so ranges never wrap. On a miss found is 0 and both other
// fields are 0. A lookup occupies the block until it leaves FINISH and stops
// scanning at the first hit. A finished lookup holds in FINISH while a full
// output register stays stalled. Results sit in an output register, so the
// next transaction is taken while an earlier result waits. Entries must be
// written before a lookup reaches them; the memory has no reset. Write
// entry_count only when idle.
module symbol_range_lookup_core #(
  parameter int TABLE_DEPTH = srl_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [srl_pkg::COUNT_W-1:0]  cfg_write_data,
  srl_in_if.sink                       request,
  srl_out_if.source                    response
);
  import srl_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t            state;
  logic [COUNT_W-1:0] entry_count;

  // scan bookkeeping
  logic [CW-1:0]     idx;
  logic [CW-1:0]     limit;
  logic [ADDR_W-1:0] address;
  logic              rd_pending;

  // result held between the scan and the output register
  logic              hit;
  logic [NAME_W-1:0] hit_name;
  logic [ADDR_W-1:0] hit_dist;

  // output register
  logic              out_valid;
  logic              out_found;
  logic [NAME_W-1:0] out_name;
  logic [ADDR_W-1:0] out_dist;

  logic              accept;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  entry_t            rd_data;

  logic [ADDR_W:0]   range_end;
  logic              match;
  logic              out_free;

  assign request.ready = (state == ST_IDLE);
  assign accept        = request.valid && request.ready;

  // Write path: drop slots beyond the table.
  assign wr_en   = accept && (request.command == CMD_WRITE)
                   && (32'(request.entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(request.entry_index);
  assign wr_data = '{start:       request.entry_start,
                     length:      request.entry_length,
                     kind:        request.entry_kind,
                     name_offset: request.entry_name_offset};

  // Read path: issue one slot per cycle while the scan runs.
  assign rd_en   = (state == ST_SCAN) && (idx < limit);
  assign rd_addr = idx[AW-1:0];

  srl_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Range test on the entry returned last cycle; the end is a 33-bit sum.
  assign range_end = {1'b0, rd_data.start} + {1'b0, rd_data.length};
  assign match     = rd_pending && (rd_data.kind == KIND_FUNCTION)
                     && (address >= rd_data.start)
                     && ({1'b0, address} < range_end);

  assign out_free = !out_valid || response.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write_en) begin
      entry_count <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_pending <= 1'b0;
      idx        <= '0;
      limit      <= '0;
      hit        <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          rd_pending <= 1'b0;
          if (accept && (request.command == CMD_LOOKUP)) begin
            idx   <= '0;
            limit <= (32'(entry_count) >= 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                             : CW'(entry_count);
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (match) begin
            // first hit wins; drop any read still in flight
            hit        <= 1'b1;
            rd_pending <= 1'b0;
            state      <= ST_FINISH;
          end else if (!rd_en && !rd_pending) begin
            hit   <= 1'b0;
            state <= ST_FINISH;
          end else begin
            rd_pending <= rd_en;
            if (rd_en) begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Latch the lookup address and the winning entry's fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      address <= request.lookup_address;
    end
    if (state == ST_SCAN) begin
      if (match) begin
        hit_name <= rd_data.name_offset;
        hit_dist <= address - rd_data.start;
      end else begin
        hit_name <= '0;
        hit_dist <= '0;
      end
    end
  end

  // Output register: load from FINISH when free, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_found <= hit;
      out_name  <= hit_name;
      out_dist  <= hit_dist;
    end
  end

  assign response.valid             = out_valid;
  assign response.found             = out_found;
  assign response.match_name_offset = out_name;
  assign response.match_offset      = out_dist;

  // The scan never reads past the capped count.
  a_idx_bound : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (idx <= limit && 32'(limit) <= 32'(TABLE_DEPTH)))
    else $error("scan index ran past the table limit");

  // A new result only ever comes out of the FINISH state.
  a_result_src : assert property (@(posedge clk) disable iff (rst)
    (response.valid && !$past(response.valid)) |-> $past(state == ST_FINISH))
    else $error("result appeared without a finished scan");

  // A miss reports zero name offset and zero distance.
  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    (response.valid && !response.found)
      |-> (response.match_name_offset == '0 && response.match_offset == '0))
    else $error("miss result carries nonzero fields");

  // The read pipeline is empty whenever the block is idle.
  a_idle_clean : assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !rd_pending)
    else $error("read still pending while idle");

endmodule

// File: rtl/srl_table.sv
// Symbol entry memory: one write port, one registered read port.
module srl_table #(
  parameter int TABLE_DEPTH = srl_pkg::DEFAULT_TABLE_DEPTH,
  parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  srl_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output srl_pkg::entry_t rd_data
);
  import srl_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: tb/sv/tb_symbol_range_lookup_core.sv
`timescale 1ns / 1ps
// Testbench for the symbol range lookup core: table writes and address lookups under backpressure.
module tb_symbol_range_lookup_core;
  import srl_pkg::*;

  localparam int DEPTH         = DEFAULT_TABLE_DEPTH;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = DEPTH + 16;
  localparam int LIMIT_CYCLES  = 2000000;

  // One request transaction as the sender sees it.
  typedef struct {
    command_t            command;
    logic [INDEX_W-1:0]  index;
    logic [ADDR_W-1:0]   start;
    logic [LENGTH_W-1:0] length;
    logic [KIND_W-1:0]   kind;
    logic [NAME_W-1:0]   name_offset;
    logic [ADDR_W-1:0]   address;
  } request_t;

  // One lookup answer as the block should return it.
  typedef struct packed {
    logic              found;
    logic [NAME_W-1:0] name_offset;
    logic [ADDR_W-1:0] distance;
  } lookup_result_t;

  logic                clk;
  logic                rst;
  logic                cfg_write_en;
  logic [COUNT_W-1:0]  cfg_write_data;

  srl_in_if  request_if ();
  srl_out_if response_if ();

  symbol_range_lookup_core #(.TABLE_DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .request        (request_if.sink),
    .response       (response_if.source)
  );

  // Shadow copy of the symbol table and the scan count.
  logic [ADDR_W-1:0]   tbl_start       [DEPTH];
  logic [LENGTH_W-1:0] tbl_length      [DEPTH];
  logic [KIND_W-1:0]   tbl_kind        [DEPTH];
  logic [NAME_W-1:0]   tbl_name_offset [DEPTH];
  bit                  tbl_written     [DEPTH];
  int                  written_prefix;     // slots 0 .. written_prefix-1 are all written
  logic [COUNT_W-1:0]  scan_count;

  lookup_result_t      pending_lookups[$];  // answers owed by the block, oldest first
  int                  mismatch_count;
  int                  cycle_count;
  bit                  idle_enabled;       // clear to run both sides back to back
  int                  hold_request;       // one-shot long hold-off for the receiver
  int                  stall_left;

  // Clock and cycle limit.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int roll;
    if (!idle_enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 48);
  endfunction

  // Scan the shadow table the way the block does: first function entry whose
  // range holds the address, range end taken at 33 bits so it never wraps.
  function automatic lookup_result_t resolve_address(logic [ADDR_W-1:0] addr);
    lookup_result_t  res;
    int              limit;
    logic [ADDR_W:0] range_end;
    res = '0;
    limit = (int'(scan_count) > DEPTH) ? DEPTH : int'(scan_count);
    for (int i = 0; i < limit; i++) begin
      range_end = {1'b0, tbl_start[i]} + {1'b0, tbl_length[i]};
      if (tbl_kind[i] == KIND_FUNCTION && addr >= tbl_start[i] && {1'b0, addr} < range_end) begin
        res.found       = 1'b1;
        res.name_offset = tbl_name_offset[i];
        res.distance    = addr - tbl_start[i];
        return res;
      end
    end
    return res;
  endfunction

  // Apply an accepted transaction to the shadow table or owe an answer.
  function automatic void record_transaction(request_t req);
    if (req.command == CMD_WRITE) begin
      tbl_start[req.index]       = req.start;
      tbl_length[req.index]      = req.length;
      tbl_kind[req.index]        = req.kind;
      tbl_name_offset[req.index] = req.name_offset;
      tbl_written[req.index]     = 1'b1;
      while (written_prefix < DEPTH && tbl_written[written_prefix]) written_prefix++;
    end else begin
      pending_lookups.push_back(resolve_address(req.address));
    end
  endfunction

  // Fields a command does not use carry random junk.
  function automatic request_t make_write(int idx, logic [ADDR_W-1:0] start,
                                          logic [LENGTH_W-1:0] len, logic [KIND_W-1:0] kind,
                                          logic [NAME_W-1:0] name);
    request_t req;
    req.command     = CMD_WRITE;
    req.index       = INDEX_W'(idx);
    req.start       = start;
    req.length      = len;
    req.kind        = kind;
    req.name_offset = name;
    req.address     = $urandom;
    return req;
  endfunction

  function automatic request_t make_lookup(logic [ADDR_W-1:0] addr);
    request_t req;
    req.command     = CMD_LOOKUP;
    req.index       = INDEX_W'($urandom);
    req.start       = $urandom;
    req.length      = $urandom;
    req.kind        = KIND_W'($urandom);
    req.name_offset = $urandom;
    req.address     = addr;
    return req;
  endfunction

  // Random entry: mostly function symbols packed into one address window so
  // lookups land on them, with empty, huge and top-of-space ranges mixed in.
  function automatic request_t random_write(int idx);
    logic [ADDR_W-1:0]   start;
    logic [LENGTH_W-1:0] len;
    logic [KIND_W-1:0]   kind;
    int                  roll;
    roll = $urandom_range(0, 99);
    if (roll < 80)      start = 32'h4000_0000 + $urandom_range(0, 'hFFFF);
    else if (roll < 90) start = 32'hFFFF_0000 + $urandom_range(0, 'hFFFF);
    else                start = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 70)      len = $urandom_range(1, 'h800);
    else if (roll < 80) len = '0;
    else if (roll < 90) len = $urandom;
    else                len = '1;
    kind = ($urandom_range(0, 3) != 0) ? KIND_FUNCTION : KIND_W'($urandom);
    return make_write(idx, start, len, kind, $urandom);
  endfunction

  // Random lookup: mostly inside or at the edges of some stored range.
  function automatic request_t random_lookup();
    int                  slot;
    int                  roll;
    logic [LENGTH_W-1:0] len;
    logic [ADDR_W-1:0]   addr;
    slot = $urandom_range(0, DEPTH - 1);
    len  = tbl_length[slot];
    roll = $urandom_range(0, 99);
    if (roll < 60)
      addr = tbl_start[slot] + ((len > 'h2000) ? $urandom : $urandom_range(0, len));
    else if (roll < 70)
      addr = tbl_start[slot] - 1;
    else if (roll < 78)
      addr = tbl_start[slot] + len;
    else
      addr = $urandom;
    return make_lookup(addr);
  endfunction

  function automatic request_t random_item();
    if ($urandom_range(0, 3) != 0) return random_lookup();
    return random_write($urandom_range(0, DEPTH - 1));
  endfunction

  // Offer one transaction, optionally after a gap, and hold it until taken.
  // Leave valid high afterwards so back-to-back items never drop it.
  task automatic send_item(input request_t req);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      request_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_if.valid             <= 1'b1;
    request_if.command           <= req.command;
    request_if.entry_index       <= req.index;
    request_if.entry_start       <= req.start;
    request_if.entry_length      <= req.length;
    request_if.entry_kind        <= req.kind;
    request_if.entry_name_offset <= req.name_offset;
    request_if.lookup_address    <= req.address;
    do @(posedge clk); while (!request_if.ready);
    record_transaction(req);
  endtask

  // Stop offering and wait until every owed answer has come back.
  task automatic wait_drained();
    request_if.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  // Write the scan count while the block is idle; a trailing write may still
  // be in flight after the last answer, so let it settle first.
  task automatic set_entry_count(input int unsigned count);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= COUNT_W'(count);
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    scan_count = COUNT_W'(count);
  endtask

  function automatic void compare_field(string field, logic [31:0] expected_v,
                                        logic [31:0] actual_v);
    if (actual_v !== expected_v) begin
      $display("%0t: %s mismatch expected %h actual %h", $time, field, expected_v, actual_v);
      mismatch_count++;
    end
  endfunction

  function automatic void check_result();
    lookup_result_t owed;
    if (pending_lookups.size() == 0) begin
      $display("%0t: result with nothing pending: found %b name %h offset %h", $time,
               response_if.found, response_if.match_name_offset, response_if.match_offset);
      mismatch_count++;
      return;
    end
    owed = pending_lookups.pop_front();
    compare_field("found", 32'(owed.found), 32'(response_if.found));
    compare_field("match_name_offset", owed.name_offset, response_if.match_name_offset);
    compare_field("match_offset", owed.distance, response_if.match_offset);
  endfunction

  // Receiver: check each accepted result, then pick the next ready. A pending
  // hold request overrides the random stalls with one long stretch.
  always @(posedge clk) begin
    if (rst) begin
      response_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (response_if.valid && response_if.ready) check_result();
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        response_if.ready <= 1'b0;
        stall_left--;
      end else begin
        response_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // With an empty scan range every lookup misses without touching the table.
  task automatic test_empty_table();
    send_item(make_lookup(32'h0000_0000));
    send_item(make_lookup(32'hFFFF_FFFF));
  endtask

  // Hand-built entries: empty range, non-function cover, overlap where the
  // first function wins, a range whose end passes the top of the address
  // space, full-space ranges and odd type nibbles.
  task automatic test_directed_entries();
    send_item(make_write(0, 32'h0000_1000, 32'h0,         KIND_FUNCTION, 32'hAAAA_0000));
    send_item(make_write(1, 32'h0000_1000, 32'h100,       4'h0,          32'h0000_0001));
    send_item(make_write(2, 32'h0000_1000, 32'h100,       KIND_FUNCTION, 32'hFFFF_FFFF));
    send_item(make_write(3, 32'h0000_1080, 32'h200,       KIND_FUNCTION, 32'h0000_0033));
    send_item(make_write(4, 32'hFFFF_FF00, 32'hFFFF_FFFF, KIND_FUNCTION, 32'h0000_0044));
    send_item(make_write(5, 32'h0000_0000, 32'hFFFF_FFFF, 4'hF,          32'h0000_0000));
    send_item(make_write(6, 32'h0000_0000, 32'hFFFF_FFFF, KIND_FUNCTION, 32'h0000_0066));
    send_item(make_write(7, 32'h8000_0000, 32'h1,         4'h3,          32'h0000_0077));
    set_entry_count(8);
    send_item(make_lookup(32'h0000_1000));
    send_item(make_lookup(32'h0000_10FF));
    send_item(make_lookup(32'h0000_1090));
    send_item(make_lookup(32'h0000_1100));
    send_item(make_lookup(32'hFFFF_FFFF));
    send_item(make_lookup(32'h0000_0000));
    send_item(make_lookup(32'hFFFF_FFFE));
    // Only the empty and non-function entries are scanned here: miss.
    set_entry_count(2);
    send_item(make_lookup(32'h0000_1000));
  endtask

  // Write every slot, then scan the full table.
  task automatic test_fill_table();
    for (int i = 0; i < DEPTH; i++) send_item(random_write(i));
    set_entry_count(DEPTH);
    repeat (60) send_item(random_lookup());
  endtask

  // Walk the scan count through its extremes, past the depth to the 9-bit top.
  task automatic test_count_settings();
    int unsigned counts [7];
    counts = '{1, DEPTH - 1, DEPTH, DEPTH + 1, (1 << COUNT_W) - 1, 0, 0};
    counts[6] = $urandom_range(2, DEPTH - 2);
    foreach (counts[i]) begin
      set_entry_count(counts[i]);
      repeat (12) send_item(random_item());
    end
  endtask

  // Hold the receiver off for a long stretch while lookups keep coming so the
  // block fills and stalls its input; then pause until all answers are in.
  task automatic test_backpressure();
    set_entry_count(16);
    idle_enabled = 1'b0;
    hold_request = 400;
    repeat (24) send_item(random_lookup());
    idle_enabled = 1'b1;
    wait_drained();
    repeat (10) send_item(random_item());
  endtask

  // Long random mix in blocks, each with its own scan count and idling mode.
  task automatic test_random_mix();
    int roll;
    for (int blk = 0; blk < 7; blk++) begin
      roll = $urandom_range(0, 2);
      if (roll == 0)      set_entry_count(DEPTH);
      else if (roll == 1) set_entry_count($urandom_range(1, DEPTH));
      else                set_entry_count($urandom_range(1, 8));
      idle_enabled = ($urandom_range(0, 3) != 0);
      repeat (60) send_item(random_item());
    end
    idle_enabled = 1'b1;
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    written_prefix = 0;
    scan_count     = '0;
    idle_enabled   = 1'b1;
    hold_request   = 0;
    foreach (tbl_written[i]) tbl_written[i] = 1'b0;

    // Drive every input to a known value from the start; hold reset.
    rst                          <= 1'b1;
    cfg_write_en                 <= 1'b0;
    cfg_write_data               <= '0;
    request_if.valid             <= 1'b0;
    request_if.command           <= CMD_WRITE;
    request_if.entry_index       <= '0;
    request_if.entry_start       <= '0;
    request_if.entry_length      <= '0;
    request_if.entry_kind        <= '0;
    request_if.entry_name_offset <= '0;
    request_if.lookup_address    <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_directed_entries();
    test_fill_table();
    test_count_settings();
    test_backpressure();
    test_random_mix();

    // Drain, then keep clocking so that any stray answer from the block shows up.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_lookups.size() != 0) begin
      $display("%0t: %0d answers never arrived", $time, pending_lookups.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/srl_pkg.sv
rtl/srl_in_if.sv
rtl/srl_out_if.sv
rtl/srl_table.sv
rtl/symbol_range_lookup_core.sv
tb/sv/tb_symbol_range_lookup_core.sv
